// ===== sv/sliding_window_median_top_defines.svh =====
// ----------------------------------------------------------------------------
// Sliding window median: assertion macros
// Shared assertion forms, clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_MEDIAN_TOP_DEFINES_SVH
`define SLIDING_WINDOW_MEDIAN_TOP_DEFINES_SVH

// Property holds at every clock edge outside reset.
`define SWM_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Condition at one edge implies a consequence at the next edge.
`define SWM_ASSERT_NEXT(name, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== sv/swm_pkg.sv =====
// ----------------------------------------------------------------------------
// Sliding window median: package
// Shared widths, register codes, controller states and cell link types.
// ----------------------------------------------------------------------------
`default_nettype none

package swm_pkg;

    localparam int SAMPLE_W = 32;
    localparam int MEDIAN_W = 33;
    localparam int WS_W     = 7;
    localparam int PDATA_W  = 32;
    localparam int PADDR_W  = 3;

    // Register index, taken from paddr[2]
    localparam logic [0:0] REG_WINDOW_SIZE = 1'b0;
    localparam logic [WS_W-1:0] WINDOW_SIZE_RESET = 7'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FIND,
        ST_UPD,
        ST_PICK,
        ST_SUM
    } swm_state_t;

    // Controller commands to the cell row
    typedef struct packed {
        logic load;
        logic flush;
        logic remove;
        logic clear;
    } swm_ctrl_t;

    // What a cell hands to the cell above it: its post-removal entry
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] value;
        logic                       valid;
        logic                       gt;
    } swm_link_t;

endpackage

`default_nettype wire

// ===== sv/swm_cell.sv =====
// ----------------------------------------------------------------------------
// Sliding window median: sorted cell
// Holds one entry of the sorted window with its age. On load it drops the
// oldest entry when remove is set and places the new sample using only its own
// compares and those of its two neighbors.
// ----------------------------------------------------------------------------
`default_nettype none

module swm_cell
    import swm_pkg::*;
#(
    parameter int AGE_W = 6,
    parameter int CNT_W = 7,
    parameter int IDX   = 0
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire swm_ctrl_t                  ctrl,
    input  wire logic signed [SAMPLE_W-1:0] sample,
    input  wire logic signed [SAMPLE_W-1:0] x_old,
    input  wire logic        [CNT_W-1:0]    w_last,
    input  wire logic        [CNT_W-1:0]    mid_lo,
    input  wire logic        [CNT_W-1:0]    mid_hi,
    input  wire logic signed [SAMPLE_W-1:0] above_value,
    input  wire logic                       above_valid,
    input  wire logic        [AGE_W-1:0]    above_age,
    input  wire swm_link_t                  below_link,
    input  wire logic        [AGE_W-1:0]    below_age,
    output logic signed [SAMPLE_W-1:0]      value,
    output logic                            valid,
    output logic        [AGE_W-1:0]         age,
    output swm_link_t                       up_link,
    output logic        [AGE_W-1:0]         up_age,
    output logic                            del,
    output logic signed [SAMPLE_W-1:0]      del_value,
    output logic signed [SAMPLE_W-1:0]      lo_value,
    output logic signed [SAMPLE_W-1:0]      hi_value
);

    logic signed [SAMPLE_W-1:0] value_reg;
    logic                       valid_reg;
    logic        [AGE_W-1:0]    age_reg;

    logic signed [SAMPLE_W-1:0] value_next;
    logic                       valid_next;
    logic        [AGE_W-1:0]    age_next;

    logic                       valid_eff;
    logic                       shift;
    logic signed [SAMPLE_W-1:0] r_value;
    logic                       r_valid;
    logic        [AGE_W-1:0]    r_age;
    logic                       r_gt;
    logic signed [SAMPLE_W-1:0] below_value;

    always_comb
    begin
        valid_eff = valid_reg & ~ctrl.flush;
        del       = valid_reg & (CNT_W'(age_reg) == w_last);

        // Oldest is the lowest of its equals, so everything at or above it is >= x_old
        shift   = ctrl.remove & valid_eff & (value_reg >= x_old);
        r_value = shift ? above_value : value_reg;
        r_valid = shift ? above_valid : valid_eff;
        r_age   = shift ? above_age   : age_reg;
        r_gt    = ~r_valid | (r_value > sample);

        up_link.value = r_value;
        up_link.valid = r_valid;
        up_link.gt    = r_gt;
        up_age        = r_age;

        below_value = below_link.value;

        if (IDX == 0)
        begin
            valid_next = 1'b1;
            if (r_gt)
            begin
                value_next = sample;
                age_next   = '0;
            end
            else
            begin
                value_next = r_value;
                age_next   = r_age + AGE_W'(1);
            end
        end
        else
        begin
            valid_next = r_valid | below_link.valid;
            if (!r_gt)
            begin
                value_next = r_value;
                age_next   = r_age + AGE_W'(1);
            end
            else if (below_link.gt)
            begin
                // insertion point lies below: move up one place
                value_next = below_value;
                age_next   = below_age + AGE_W'(1);
            end
            else
            begin
                value_next = sample;
                age_next   = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctrl.clear)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctrl.load)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            value_reg <= value_next;
            age_reg   <= age_next;
        end
    end

    assign value     = value_reg;
    assign valid     = valid_reg;
    assign age       = age_reg;
    assign del_value = del ? value_reg : '0;
    assign lo_value  = (valid_reg && (CNT_W'(IDX) == mid_lo)) ? value_reg : '0;
    assign hi_value  = (valid_reg && (CNT_W'(IDX) == mid_hi)) ? value_reg : '0;

endmodule

`default_nettype wire

// ===== sv/swm_chain.sv =====
// ----------------------------------------------------------------------------
// Sliding window median: cell row
// A row of sorted cells, lowest value in cell 0, with neighbor links and
// the OR collection of the oldest entry and the two middle entries.
// ----------------------------------------------------------------------------
`default_nettype none

module swm_chain
    import swm_pkg::*;
#(
    parameter int CELLS = 64,
    parameter int AGE_W = 6,
    parameter int CNT_W = 7
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire swm_ctrl_t                  ctrl,
    input  wire logic signed [SAMPLE_W-1:0] sample,
    input  wire logic signed [SAMPLE_W-1:0] x_old,
    input  wire logic        [CNT_W-1:0]    w_last,
    input  wire logic        [CNT_W-1:0]    mid_lo,
    input  wire logic        [CNT_W-1:0]    mid_hi,
    output logic signed [SAMPLE_W-1:0]      oldest_value,
    output logic signed [SAMPLE_W-1:0]      lo_value,
    output logic signed [SAMPLE_W-1:0]      hi_value,
    output logic        [CELLS-1:0]         valid_vec,
    output logic        [CELLS-1:0]         del_vec
);

    logic signed [SAMPLE_W-1:0] own_value [CELLS];
    logic        [AGE_W-1:0]    own_age   [CELLS];
    swm_link_t                  link      [CELLS];
    logic        [AGE_W-1:0]    link_age  [CELLS];
    logic signed [SAMPLE_W-1:0] del_pick  [CELLS];
    logic signed [SAMPLE_W-1:0] lo_pick   [CELLS];
    logic signed [SAMPLE_W-1:0] hi_pick   [CELLS];

    for (genvar i = 0; i < CELLS; i++)
    begin : g_cell
        logic signed [SAMPLE_W-1:0] above_value;
        logic                       above_valid;
        logic        [AGE_W-1:0]    above_age;
        swm_link_t                  below_link;
        logic        [AGE_W-1:0]    below_age;

        if (i == CELLS - 1)
        begin : g_top
            assign above_value = '0;
            assign above_valid = 1'b0;
            assign above_age   = '0;
        end
        else
        begin : g_mid
            assign above_value = own_value[i+1];
            assign above_valid = valid_vec[i+1];
            assign above_age   = own_age[i+1];
        end

        if (i == 0)
        begin : g_bottom
            assign below_link = '0;
            assign below_age  = '0;
        end
        else
        begin : g_link
            assign below_link = link[i-1];
            assign below_age  = link_age[i-1];
        end

        swm_cell #(
            .AGE_W (AGE_W),
            .CNT_W (CNT_W),
            .IDX   (i)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .sample      (sample),
            .x_old       (x_old),
            .w_last      (w_last),
            .mid_lo      (mid_lo),
            .mid_hi      (mid_hi),
            .above_value (above_value),
            .above_valid (above_valid),
            .above_age   (above_age),
            .below_link  (below_link),
            .below_age   (below_age),
            .value       (own_value[i]),
            .valid       (valid_vec[i]),
            .age         (own_age[i]),
            .up_link     (link[i]),
            .up_age      (link_age[i]),
            .del         (del_vec[i]),
            .del_value   (del_pick[i]),
            .lo_value    (lo_pick[i]),
            .hi_value    (hi_pick[i])
        );
    end

    // At most one cell matches each pick, so an OR collects it
    always_comb
    begin
        oldest_value = '0;
        lo_value     = '0;
        hi_value     = '0;
        for (int i = 0; i < CELLS; i++)
        begin
            oldest_value = oldest_value | del_pick[i];
            lo_value     = lo_value | lo_pick[i];
            hi_value     = hi_value | hi_pick[i];
        end
    end

endmodule

`default_nettype wire

// ===== sv/sliding_window_median_top.sv =====
// ----------------------------------------------------------------------------
// Sliding window median: top level
// A request producing a result shows it on out_valid once the controller has passed
// find-oldest, cell update, middle pick and sum in turn; sum waits for a free output register.
// A filling request returns to idle after the cell update; requests are taken only in idle.
// The output register holds a finished result while the next request is taken.
// Reset: window_size returns to 3, the window is empty, no result pending.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sliding_window_median_top_defines.svh"

module sliding_window_median_top
    import swm_pkg::*;
#(
    parameter int WINDOW_MAX = 64
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic signed [SAMPLE_W-1:0] sample,
    input  wire logic                       start_req,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic signed [MEDIAN_W-1:0]      median_doubled,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic        [PADDR_W-1:0]  paddr,
    input  wire logic        [PDATA_W-1:0]  pwdata,
    output logic             [PDATA_W-1:0]  prdata,
    output logic                            pready
);

    localparam int AGE_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int CNT_W = $clog2(WINDOW_MAX + 1);
    localparam int CMP_W = (CNT_W > WS_W) ? CNT_W : WS_W;

    swm_state_t                 state_reg;
    swm_state_t                 state_next;
    logic        [WS_W-1:0]     window_size_reg;
    logic        [CNT_W-1:0]    fill_reg;
    logic        [CNT_W-1:0]    fill_next;
    logic                       out_valid_reg;
    logic signed [MEDIAN_W-1:0] median_reg;
    logic signed [SAMPLE_W-1:0] sample_reg;
    logic                       start_reg;
    logic signed [SAMPLE_W-1:0] x_reg;
    logic signed [SAMPLE_W-1:0] lo_reg;
    logic signed [SAMPLE_W-1:0] hi_reg;

    logic        [CMP_W-1:0]    ws_ext;
    logic        [CNT_W-1:0]    w_eff;
    logic        [CNT_W-1:0]    w_last;
    logic        [CNT_W-1:0]    mid_lo;
    logic        [CNT_W-1:0]    mid_hi;
    logic                       full;
    logic                       cfg_write;
    logic                       in_take;
    logic                       out_free;
    swm_ctrl_t                  ctrl;

    logic signed [SAMPLE_W-1:0] oldest_value;
    logic signed [SAMPLE_W-1:0] lo_value;
    logic signed [SAMPLE_W-1:0] hi_value;
    logic        [WINDOW_MAX-1:0] valid_vec;
    logic        [WINDOW_MAX-1:0] del_vec;

    // Effective window: zero acts as one, oversize saturates
    always_comb
    begin
        ws_ext = CMP_W'(window_size_reg);
        if (ws_ext == '0)
        begin
            w_eff = CNT_W'(1);
        end
        else if (ws_ext > CMP_W'(WINDOW_MAX))
        begin
            w_eff = CNT_W'(WINDOW_MAX);
        end
        else
        begin
            w_eff = CNT_W'(ws_ext);
        end
        w_last = w_eff - CNT_W'(1);
        mid_hi = w_eff >> 1;
        mid_lo = w_last >> 1;
    end

    assign full      = (fill_reg >= w_eff) & ~start_reg;
    assign cfg_write = psel & penable & pwrite & pready & (paddr[2:2] == REG_WINDOW_SIZE);
    assign in_take   = in_valid & ~in_stall;
    assign out_free  = ~out_valid_reg | ~out_stall;

    always_comb
    begin
        if (start_reg)
        begin
            fill_next = CNT_W'(1);
        end
        else if (full)
        begin
            fill_next = w_eff;
        end
        else
        begin
            fill_next = fill_reg + CNT_W'(1);
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_FIND;
                end
            end
            ST_FIND:
            begin
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                state_next = (fill_next == w_eff) ? ST_PICK : ST_IDLE;
            end
            ST_PICK:
            begin
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Controller outputs
    always_comb
    begin
        in_stall    = 1'b1;
        ctrl.load   = 1'b0;
        ctrl.flush  = start_reg;
        ctrl.remove = 1'b0;
        ctrl.clear  = cfg_write;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
            end
            ST_UPD:
            begin
                ctrl.load   = 1'b1;
                ctrl.remove = full;
            end
            ST_FIND, ST_PICK, ST_SUM:
            begin
                in_stall = 1'b1;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            window_size_reg <= WINDOW_SIZE_RESET;
            fill_reg        <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write)
            begin
                window_size_reg <= pwdata[WS_W-1:0];
                fill_reg        <= '0;
            end
            else if (state_reg == ST_UPD)
            begin
                fill_reg <= fill_next;
            end
            if (state_reg == ST_SUM && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            sample_reg <= sample;
            start_reg  <= start_req;
        end
        if (state_reg == ST_FIND)
        begin
            x_reg <= oldest_value;
        end
        if (state_reg == ST_PICK)
        begin
            lo_reg <= lo_value;
            hi_reg <= hi_value;
        end
        if (state_reg == ST_SUM && out_free)
        begin
            median_reg <= MEDIAN_W'(lo_reg) + MEDIAN_W'(hi_reg);
        end
    end

    swm_chain #(
        .CELLS (WINDOW_MAX),
        .AGE_W (AGE_W),
        .CNT_W (CNT_W)
    ) u_chain (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .sample       (sample_reg),
        .x_old        (x_reg),
        .w_last       (w_last),
        .mid_lo       (mid_lo),
        .mid_hi       (mid_hi),
        .oldest_value (oldest_value),
        .lo_value     (lo_value),
        .hi_value     (hi_value),
        .valid_vec    (valid_vec),
        .del_vec      (del_vec)
    );

    always_comb
    begin
        prdata = '0;
        unique case (paddr[2:2])
            REG_WINDOW_SIZE:
            begin
                prdata = PDATA_W'(window_size_reg);
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    assign pready         = 1'b1;
    assign out_valid      = out_valid_reg;
    assign median_doubled = median_reg;

    `SWM_ASSERT(a_fill_bound, fill_reg <= w_eff, "fill count exceeds window")
    `SWM_ASSERT(a_fill_cells,
        (state_reg == ST_IDLE) |-> ($countones(valid_vec) == fill_reg),
        "cell valid count differs from fill count")
    `SWM_ASSERT(a_one_oldest,
        ((state_reg == ST_FIND) && full) |-> $onehot(del_vec),
        "full window without exactly one oldest cell")
    `SWM_ASSERT_NEXT(a_sum_load, (state_reg == ST_SUM) && out_free,
        out_valid_reg && (state_reg == ST_IDLE),
        "sum not delivered to output register")

endmodule

`default_nettype wire
